FILE: src/cgc_pkg.sv
// ----------------------------------------------------------------------------
// cgc_pkg: shared types and constants
// Field widths, the controller state type and the colour-pick result struct
// used by the capacity-limited greedy colouring block.
// ----------------------------------------------------------------------------
package cgc_pkg;

    // Default number of elements held in the colour store
    localparam int MAX_ELEMENTS_DEF = 64;

    // Fixed field widths
    localparam int MASK_W  = 64;   // adjacency mask
    localparam int COLOR_W = 7;    // colour, 0 = uncoloured
    localparam int IDX_W   = 6;    // element index on the result
    localparam int CNT_W   = 7;    // element / colour / member counts

    // Reset value of the capacity register
    localparam logic [COLOR_W-1:0] CAP_RESET = 7'd32;

    // Controller state
    typedef enum logic {
        ST_IDLE,
        ST_PICK
    } t_state;

    // Result of the lowest-free-colour search
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;   // colour minus one
    } t_pick;

endpackage

FILE: src/cgc_lane.sv
// ----------------------------------------------------------------------------
// cgc_lane: one neighbour lane
// Decodes the stored colour of one element into a one-hot vector of blocked
// colours, gated by the element's mask bit and whether it is coloured yet.
// ----------------------------------------------------------------------------
module cgc_lane
    import cgc_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                    i_enable,
    input  logic [COLOR_W-1:0]      i_color,
    output logic [MAX_ELEMENTS-1:0] o_hit
);

    // Bit j marks colour j+1 as held by this neighbour
    always_comb begin
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
            o_hit[j] = i_enable && (i_color == COLOR_W'(j + 1));
        end
    end

endmodule

FILE: src/cgc_merge.sv
// ----------------------------------------------------------------------------
// cgc_merge: lane merge
// Combines the per-lane hit vectors into one mask of blocked colours.
// ----------------------------------------------------------------------------
module cgc_merge
    import cgc_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic [MAX_ELEMENTS-1:0] i_hits [MAX_ELEMENTS],
    output logic [MAX_ELEMENTS-1:0] o_blocked
);

    // OR every lane's hits together
    always_comb begin
        o_blocked = '0;
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
            o_blocked = o_blocked | i_hits[k];
        end
    end

endmodule

FILE: src/cgc_pick.sv
// ----------------------------------------------------------------------------
// cgc_pick: lowest qualifying colour
// Priority encoder over the per-colour qualify vector; lowest colour wins.
// ----------------------------------------------------------------------------
module cgc_pick
    import cgc_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic [MAX_ELEMENTS-1:0] i_qualify,
    output t_pick                   o_pick
);

    // Scan from the top so the lowest set bit is left standing
    always_comb begin
        o_pick = '0;
        for (int j = MAX_ELEMENTS - 1; j >= 0; j--) begin
            if (i_qualify[j]) begin
                o_pick.found = 1'b1;
                o_pick.index = IDX_W'(j);
            end
        end
    end

endmodule

FILE: src/capacity_limited_greedy_coloring.sv
// ----------------------------------------------------------------------------
// capacity_limited_greedy_coloring: greedy mesh colouring with capacity
// Colours mesh elements in arrival order with the lowest colour free of
// coloured neighbours and below the per-colour member limit.
// ----------------------------------------------------------------------------
// Each item is one element's adjacency mask (tdata) with a start-of-mesh flag
// (tuser). On accept, one lane per stored element decodes that neighbour's
// colour and the lanes are merged into a registered blocked-colour mask; then
// in ST_PICK, once the output register is free, the lowest colour in use,
// unblocked and below max_per_color is picked (else a new colour is opened),
// the colour and member stores are updated and the result is loaded into the
// output register. The next item is taken only once that update is done.
// Element and member stores need no clearing: the element count and the
// colour count mark which entries hold data, so a start flag takes effect at
// once. Past MAX_ELEMENTS elements the result is colour 0, index 0 with the
// overflow flag set, until a new mesh starts. max_per_color may only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module capacity_limited_greedy_coloring
    import cgc_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [COLOR_W-1:0]   i_cfg_data,     // max_per_color
    // input items
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [MASK_W-1:0]    i_s_axis_tdata, // [63:0] neighbor_mask
    input  logic                 i_s_axis_tuser, // [0] start_new
    // result items
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata, // [6:0] color, [12:7] element_index
    output logic                 o_m_axis_tuser  // [0] overflow
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    // Control and configuration registers
    t_state              r_state, n_state;
    logic [COLOR_W-1:0]  r_max_per_color;
    logic [CNT_W-1:0]    r_next_element;
    logic [CNT_W-1:0]    r_colors_in_use;

    // Stores
    logic [COLOR_W-1:0]  r_elem_color [MAX_ELEMENTS];
    logic [CNT_W-1:0]    r_members    [MAX_ELEMENTS];

    // Lookup stage
    logic [MAX_ELEMENTS-1:0] w_hits [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] w_blocked;
    logic [MAX_ELEMENTS-1:0] r_blocked;
    logic [CNT_W-1:0]        w_eff_next;

    // Pick stage
    logic [MAX_ELEMENTS-1:0] w_qualify;
    t_pick                   w_pick;
    logic                    w_overflow;
    logic [COLOR_W-1:0]      w_color;

    // Output register
    logic                r_out_valid;
    logic [COLOR_W-1:0]  r_out_color;
    logic [IDX_W-1:0]    r_out_index;
    logic                r_out_ovf;

    // Handshake strobes
    logic w_in_fire;
    logic w_pick_fire;

    assign o_cfg_ready = 1'b1;

    // A start flag empties the mesh before this element is looked up
    assign w_eff_next = i_s_axis_tuser ? '0 : r_next_element;

    // One lane per stored element
    for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_lane
        localparam logic [CNT_W-1:0] K_CNT = CNT_W'(k);
        cgc_lane #(
            .MAX_ELEMENTS (MAX_ELEMENTS)
        ) u_lane (
            .i_enable (i_s_axis_tdata[k] && (K_CNT < w_eff_next)),
            .i_color  (r_elem_color[k]),
            .o_hit    (w_hits[k])
        );
    end

    cgc_merge #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_merge (
        .i_hits    (w_hits),
        .o_blocked (w_blocked)
    );

    // Colour qualifies when in use, unblocked and below capacity
    always_comb begin
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
            w_qualify[j] = (CNT_W'(j) < r_colors_in_use) && !r_blocked[j]
                           && (r_members[j] < r_max_per_color);
        end
    end

    cgc_pick #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_pick (
        .i_qualify (w_qualify),
        .o_pick    (w_pick)
    );

    assign w_overflow = (r_next_element >= MAX_CNT);
    assign w_color    = w_pick.found ? (COLOR_W'(w_pick.index) + COLOR_W'(1))
                                     : (r_colors_in_use + CNT_W'(1));

    // Next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_pick_fire     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_pick_fire = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_in_fire = i_s_axis_tvalid && o_s_axis_tready;

    // Hold state, counters and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_max_per_color <= CAP_RESET;
            r_next_element  <= '0;
            r_colors_in_use <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_max_per_color <= i_cfg_data;
            end
            if (w_in_fire && i_s_axis_tuser) begin
                r_next_element  <= '0;
                r_colors_in_use <= '0;
            end
            if (w_pick_fire && !w_overflow) begin
                r_next_element <= r_next_element + CNT_W'(1);
                if (!w_pick.found) begin
                    r_colors_in_use <= r_colors_in_use + CNT_W'(1);
                end
            end
            if (w_pick_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Register the blocked mask of the accepted item
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_blocked <= w_blocked;
        end
    end

    // Update the element and member stores
    always_ff @(posedge i_clk) begin
        if (w_pick_fire && !w_overflow) begin
            r_elem_color[r_next_element[AW-1:0]] <= w_color;
            if (w_pick.found) begin
                r_members[w_pick.index[AW-1:0]] <=
                    r_members[w_pick.index[AW-1:0]] + CNT_W'(1);
            end else begin
                r_members[r_colors_in_use[AW-1:0]] <= CNT_W'(1);
            end
        end
    end

    // Load the result
    always_ff @(posedge i_clk) begin
        if (w_pick_fire) begin
            r_out_ovf <= w_overflow;
            if (w_overflow) begin
                r_out_color <= '0;
                r_out_index <= '0;
            end else begin
                r_out_color <= w_color;
                r_out_index <= r_next_element[IDX_W-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_index, r_out_color};
    assign o_m_axis_tuser  = r_out_ovf;

endmodule
